@@ design/gecm_pkg.sv @@
`timescale 1ns / 1ps
package gecm_pkg;

    localparam int CHANNELS  = 16;
    localparam int CH_W      = 4;
    localparam int TIME_BITS = 32;
    localparam int MAX_RES   = CHANNELS + 1;
    localparam int RES_W     = $clog2(MAX_RES + 1);
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 152;

    localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
    localparam logic [15:0]          DEB_MAX     = 16'hFFFF;
    localparam logic [15:0]          DEB_RESET   = 16'd100;
    localparam logic [15:0]          PULLUP_ONES = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_QUERY = 2'd2
    } t_act;

    typedef enum logic [1:0] {
        KIND_CH    = 2'd0,
        KIND_ALL   = 2'd1,
        KIND_MONO  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALL,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CFG_DIR     = 3'd0,
        CFG_DEB     = 3'd1,
        CFG_CPER    = 3'd2,
        CFG_RMASK   = 3'd3,
        CFG_COMASK  = 3'd4,
        CFG_APER    = 3'd5,
        CFG_ACO     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_act        act;
        logic [15:0] pins;
        logic [3:0]  ch;
        logic        level;
        logic [31:0] mono;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] ch;
        logic       chg;
        logic       val;
    } t_res;

    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [31:0] v);
        if (v > 32'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return v[TIME_BITS-1:0];
    endfunction

endpackage

@@ design/gecm_front.sv @@
`timescale 1ns / 1ps
module gecm_front
    import gecm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pin_values, channel, level, monoflop_ms, zero pad
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [1:0]           s_axis_tuser,
    output t_item                o_item,
    output logic                 o_item_valid,
    input  logic                 i_item_pop
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_keep;
    logic       w_push;

    always_comb begin
        w_item.pins  = s_axis_tdata[15:0];
        w_item.ch    = s_axis_tdata[19:16];
        w_item.level = s_axis_tdata[20];
        w_item.mono  = s_axis_tdata[52:21];
        w_keep       = 1'b1;
        case (s_axis_tuser)
            ACT_TICK:  w_item.act = ACT_TICK;
            ACT_SET:   w_item.act = ACT_SET;
            ACT_QUERY: w_item.act = ACT_QUERY;
            default: begin
                w_item.act = ACT_TICK;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready && w_keep;
    assign o_item        = r_mem[r_rp];
    assign o_item_valid  = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_pop);
        end
    end

endmodule

@@ design/gecm_engine.sv @@
`timescale 1ns / 1ps
module gecm_engine
    import gecm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wr_data,
    input  t_item                 i_item,
    input  logic                  i_item_valid,
    output logic                  o_item_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic [15:0]          r_dir, r_deb, r_rmask, r_comask;
    logic [31:0]          r_cper, r_aper;
    logic                 r_aco;
    logic [15:0]          r_lev, r_opins, r_rlast, r_alast, r_elast;
    logic [31:0]          r_rise [CHANNELS];
    logic [31:0]          r_fall [CHANNELS];
    logic [TIME_BITS-1:0] r_rel  [CHANNELS];
    logic [15:0]          r_del  [CHANNELS];
    logic [TIME_BITS-1:0] r_mono [CHANNELS];
    logic [CHANNELS-1:0]  r_rise_v, r_fall_v, r_rel_v, r_del_v, r_mono_v;
    logic [TIME_BITS-1:0] r_all_el;

    t_state               r_state, n_state;
    logic [CH_W-1:0]      r_idx;
    logic [15:0]          r_pins;
    logic                 r_all_due;
    logic [15:0]          r_cmask, r_vmask;
    t_res                 r_buf [MAX_RES];
    logic [RES_W-1:0]     r_cnt, r_rd;
    logic [31:0]          r_q_r, r_q_f, r_q_rem;

    logic                 r_ov, r_olast;
    t_kind                r_okind;
    logic [3:0]           r_och;
    logic                 r_ochg, r_oval;
    logic [15:0]          r_ocmask, r_ovmask, r_oolev;
    logic [31:0]          r_orise, r_ofall, r_orem;

    logic [CH_W-1:0]      w_a;
    logic [31:0]          w_rise, w_fall;
    logic [TIME_BITS-1:0] w_rel, w_rel_inc, w_mono, w_cper, w_aper, w_ae_inc;
    logic [15:0]          w_del, w_del_inc;
    logic                 w_in, w_v, w_rep_hit, w_chg, w_rep_push, w_deb_hit, w_mono_fire;
    logic                 w_in_range, w_q_val;
    logic                 w_start, w_emit, w_load;
    t_res                 w_ent;

    assign w_a    = (r_state == ST_IDLE) ? i_item.ch : r_idx;
    assign w_rise = r_rise_v[w_a] ? r_rise[w_a] : 32'd0;
    assign w_fall = r_fall_v[w_a] ? r_fall[w_a] : 32'd0;
    assign w_rel  = r_rel_v[w_a] ? r_rel[w_a] : '0;
    assign w_del  = r_del_v[w_a] ? r_del[w_a] : 16'd0;
    assign w_mono = r_mono_v[w_a] ? r_mono[w_a] : '0;
    assign w_cper = clamp_time(r_cper);
    assign w_aper = clamp_time(r_aper);

    assign w_in        = r_dir[r_idx];
    assign w_v         = r_pins[r_idx];
    assign w_rel_inc   = (w_rel == TIME_MAX) ? w_rel : w_rel + 1'b1;
    assign w_rep_hit   = (w_cper != '0) && r_rmask[r_idx] && (w_rel_inc >= w_cper);
    assign w_chg       = r_rlast[r_idx] != w_v;
    assign w_rep_push  = w_rep_hit && (!r_comask[r_idx] || w_chg);
    assign w_del_inc   = (w_del == DEB_MAX) ? w_del : w_del + 16'd1;
    assign w_deb_hit   = w_del_inc >= r_deb;
    assign w_mono_fire = (w_mono == TIME_BITS'(1));
    assign w_ae_inc    = (r_all_el == TIME_MAX) ? r_all_el : r_all_el + 1'b1;
    assign w_in_range  = 32'(i_item.ch) < 32'(CHANNELS);
    assign w_q_val     = r_dir[i_item.ch] ? r_lev[i_item.ch] : r_opins[i_item.ch];

    assign w_ent = r_buf[r_rd];
    assign w_emit = (r_state == ST_EMIT) && (r_cnt != '0) && (!r_ov || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid && i_item.act == ACT_TICK) begin
                    n_state = ST_SCAN;
                end else if (i_item_valid && i_item.act == ACT_QUERY) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (r_idx == CH_W'(CHANNELS - 1)) begin
                    n_state = ST_ALL;
                end
            end
            ST_ALL: n_state = ST_EMIT;
            ST_EMIT: begin
                if (r_cnt == '0 || (w_emit && r_rd == r_cnt - 1'b1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_start    = 1'b0;
        w_load     = 1'b0;
        o_item_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_item_pop = i_item_valid;
                w_start    = i_item_valid;
            end
            ST_EMIT: w_load = w_emit;
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= PULLUP_ONES;
            r_deb     <= DEB_RESET;
            r_cper    <= 32'd0;
            r_rmask   <= 16'd0;
            r_comask  <= 16'd0;
            r_aper    <= 32'd0;
            r_aco     <= 1'b0;
            r_lev     <= PULLUP_ONES;
            r_opins   <= 16'd0;
            r_rlast   <= PULLUP_ONES;
            r_alast   <= PULLUP_ONES;
            r_elast   <= PULLUP_ONES;
            r_rise_v  <= '0;
            r_fall_v  <= '0;
            r_rel_v   <= '0;
            r_del_v   <= '0;
            r_mono_v  <= '0;
            r_all_el  <= '0;
            r_cnt     <= '0;
            r_rd      <= '0;
            r_idx     <= '0;
            r_all_due <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_DIR: begin
                        r_dir    <= i_cfg_wr_data[15:0];
                        r_mono_v <= r_mono_v & ~i_cfg_wr_data[CHANNELS-1:0];
                    end
                    CFG_DEB: begin
                        r_deb   <= i_cfg_wr_data[15:0];
                        r_del_v <= '0;
                    end
                    CFG_CPER: begin
                        r_cper  <= i_cfg_wr_data;
                        r_rel_v <= '0;
                    end
                    CFG_RMASK:  r_rmask  <= i_cfg_wr_data[15:0];
                    CFG_COMASK: r_comask <= i_cfg_wr_data[15:0];
                    CFG_APER: begin
                        r_aper   <= i_cfg_wr_data;
                        r_all_el <= '0;
                    end
                    CFG_ACO: r_aco <= i_cfg_wr_data[0];
                    default: r_aco <= r_aco;
                endcase
            end

            if (w_start) begin
                case (i_item.act)
                    ACT_TICK: begin
                        r_pins    <= i_item.pins;
                        r_idx     <= '0;
                        r_cnt     <= '0;
                        r_rd      <= '0;
                        r_cmask   <= 16'd0;
                        r_vmask   <= 16'd0;
                        r_all_due <= (w_aper != '0) && (w_ae_inc >= w_aper);
                        if (w_aper != '0) begin
                            r_all_el <= w_ae_inc;
                        end
                    end
                    ACT_SET: begin
                        if (w_in_range && !r_dir[i_item.ch]) begin
                            r_opins[i_item.ch]  <= i_item.level;
                            r_mono[i_item.ch]   <= clamp_time(i_item.mono);
                            r_mono_v[i_item.ch] <= 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        r_buf[0] <= '{kind: KIND_QUERY, ch: i_item.ch, chg: 1'b0,
                                      val: w_in_range && w_q_val};
                        r_cnt   <= RES_W'(1);
                        r_rd    <= '0;
                        r_q_r   <= w_in_range ? w_rise : 32'd0;
                        r_q_f   <= w_in_range ? w_fall : 32'd0;
                        r_q_rem <= w_in_range ? 32'(w_mono) : 32'd0;
                    end
                    default: r_cnt <= r_cnt;
                endcase
            end

            if (r_state == ST_SCAN) begin
                r_idx <= r_idx + 1'b1;
                if (w_in) begin
                    r_lev[r_idx]   <= w_v;
                    r_rel_v[r_idx] <= 1'b1;
                    r_rel[r_idx]   <= w_rep_hit ? '0 : w_rel_inc;
                    if (w_rep_hit) begin
                        r_rlast[r_idx] <= w_v;
                    end
                    if (w_rep_push) begin
                        r_buf[r_cnt] <= '{kind: KIND_CH, ch: r_idx, chg: w_chg, val: w_v};
                        r_cnt        <= r_cnt + 1'b1;
                    end
                    if (r_all_due) begin
                        r_cmask[r_idx] <= r_alast[r_idx] != w_v;
                        r_vmask[r_idx] <= w_v;
                        r_alast[r_idx] <= w_v;
                    end
                    r_del_v[r_idx] <= 1'b1;
                    r_del[r_idx]   <= w_deb_hit ? 16'd0 : w_del_inc;
                    if (w_deb_hit) begin
                        r_elast[r_idx] <= w_v;
                        if (!r_elast[r_idx] && w_v) begin
                            r_rise[r_idx]   <= w_rise + 32'd1;
                            r_rise_v[r_idx] <= 1'b1;
                        end else if (r_elast[r_idx] && !w_v) begin
                            r_fall[r_idx]   <= w_fall + 32'd1;
                            r_fall_v[r_idx] <= 1'b1;
                        end
                    end
                end else if (w_mono != '0) begin
                    r_mono[r_idx] <= w_mono - 1'b1;
                    if (w_mono_fire) begin
                        r_opins[r_idx] <= ~r_opins[r_idx];
                        r_buf[r_cnt]   <= '{kind: KIND_MONO, ch: r_idx, chg: 1'b0,
                                            val: ~r_opins[r_idx]};
                        r_cnt          <= r_cnt + 1'b1;
                    end
                end
            end

            if (r_state == ST_ALL && r_all_due) begin
                r_all_el <= '0;
                if (!r_aco || r_cmask != 16'd0) begin
                    r_buf[r_cnt] <= '{kind: KIND_ALL, ch: 4'd0, chg: 1'b0, val: 1'b0};
                    r_cnt        <= r_cnt + 1'b1;
                end
            end

            if (w_load) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_okind  <= w_ent.kind;
            r_och    <= w_ent.ch;
            r_ochg   <= w_ent.chg;
            r_oval   <= w_ent.val;
            r_ocmask <= (w_ent.kind == KIND_ALL) ? r_cmask : 16'd0;
            r_ovmask <= (w_ent.kind == KIND_ALL) ? r_vmask : 16'd0;
            r_oolev  <= r_opins;
            r_orise  <= (w_ent.kind == KIND_QUERY) ? r_q_r : 32'd0;
            r_ofall  <= (w_ent.kind == KIND_QUERY) ? r_q_f : 32'd0;
            r_orem   <= (w_ent.kind == KIND_QUERY) ? r_q_rem : 32'd0;
            r_olast  <= (r_rd == r_cnt - 1'b1);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'b00, r_orem, r_ofall, r_orise, r_oolev, r_ovmask, r_ocmask,
                            r_oval, r_ochg, r_och};

endmodule

@@ design/gpio16_edge_count_monoflop_reporter.sv @@
`timescale 1ns / 1ps
// Sequence: a tick starts a scan of the 16 channels in turn, then the all-channel
// report, then one result per cycle into the output register while the output is not stalled (up to 17).
// A query goes from idle straight to the output stage for its reply; a set gives no result.
// The engine takes one item at a time and pops the next only when back in idle.
// Reset: synchronous, active low; registers and pin state return to their defaults.
module gpio16_edge_count_monoflop_reporter
    import gecm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pin_values[15:0], channel[19:16], level[20], monoflop_ms[52:21], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // channel_index[3:0], changed[4], value[5], changed_mask[21:6], value_mask[37:22],
    // output_levels[53:38], rising_count[85:54], falling_count[117:86],
    // remaining_ms[149:118], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_pop;

    gecm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    gecm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_item_pop    (w_item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_all_no_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ALL |-> m_axis_tdata[5:0] == 6'd0)
        else $error("all-channel report carries channel fields");

    a_counts_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_QUERY |-> m_axis_tdata[149:54] == '0)
        else $error("counts outside a query reply");

    a_masks_only_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_ALL |-> m_axis_tdata[37:6] == '0)
        else $error("masks outside an all-channel report");

endmodule
